@@ hdl/shelf_atlas_allocator_core_assert.svh @@
// assertion macros for the allocator rtl
`ifndef SHELF_ATLAS_ALLOCATOR_CORE_ASSERT_SVH
`define SHELF_ATLAS_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SAA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SAA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/saa_pkg.sv @@
package saa_pkg;

    // field widths
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int PAGE_OUT_W = 3;
    localparam int PROD_W     = 16;

    // page size limits and reset values
    localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;
    localparam logic [DIM_W-1:0] PW_RESET  = 13'd2048;
    localparam logic [DIM_W-1:0] PH_RESET  = 13'd1024;

    // default sizing
    localparam int DEF_MAX_PAGES   = 8;
    localparam int DEF_MAX_SHELVES = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT = 1'b1;

    // shelf fit ratio 7/10 and growth ratio 11/10
    localparam logic [PROD_W-1:0] FIT_NUM   = 16'd7;
    localparam logic [PROD_W-1:0] FIT_DEN   = 16'd10;
    localparam logic [PROD_W-1:0] GROW_NUM  = 16'd11;
    // x/10 as (x * 52429) >> 19, exact for x below 81920
    localparam int RECIP_W     = 33;
    localparam logic [RECIP_W-1:0] RECIP_10 = 33'd52429;
    localparam int RECIP_SHIFT = 19;

    typedef enum logic [1:0] {
        STAT_PLACED   = 2'd0,
        STAT_OVERSIZE = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_NEXT,
        ST_PAGE,
        ST_SCAN,
        ST_TRYNEW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] cursor;
        logic [DIM_W-1:0] start_y;
    } t_shelf;

    // positions of 4096 saturate to 4095
    function automatic logic [POS_W-1:0] clip_pos(input logic [DIM_W-1:0] v);
        clip_pos = v[DIM_W-1] ? {POS_W{1'b1}} : v[POS_W-1:0];
    endfunction

endpackage

@@ hdl/shelf_atlas_allocator_core.sv @@
// an oversized request finishes after the prep state; otherwise the search walks the pages in order,
//   scanning the shelves of each page, one shelf read per cycle, before trying a new shelf on it
// requests are handled one at a time: a new request is taken only after the last result is loaded
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low; clears page count, shelf counts, fill lines, page size
//   registers (2048 x 1024); the shelf memory is not cleared and needs no clearing pass
`include "shelf_atlas_allocator_core_assert.svh"

module shelf_atlas_allocator_core
    import saa_pkg::*;
#(
    parameter int MAX_PAGES   = DEF_MAX_PAGES,
    parameter int MAX_SHELVES = DEF_MAX_SHELVES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // rect_width[12:0], rect_height[25:13]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata   // status[1:0], page_number[4:2],
                                                // x_position[16:5], y_position[28:17]
);

    localparam int PGC_W  = $clog2(MAX_PAGES + 1);
    localparam int PGI_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SHC_W  = $clog2(MAX_SHELVES + 1);
    localparam int DEPTH  = MAX_PAGES * MAX_SHELVES;
    localparam int AD_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BASE_W = $clog2(DEPTH + 1);
    localparam logic [PGC_W-1:0]  PAGES_MAX   = PGC_W'(MAX_PAGES);
    localparam logic [SHC_W-1:0]  SHELVES_MAX = SHC_W'(MAX_SHELVES);
    localparam logic [BASE_W-1:0] BASE_STEP   = BASE_W'(MAX_SHELVES);

    // configuration registers
    logic [DIM_W-1:0] r_cfg_pw;
    logic [DIM_W-1:0] r_cfg_ph;

    // sequencer
    t_state r_state;
    t_state n_state;

    // request held for the search
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [DIM_W-1:0]  r_pw;
    logic [DIM_W-1:0]  r_ph;
    logic [PROD_W-1:0] r_h10p9;
    logic [PROD_W-1:0] r_h11;
    logic [DIM_W-1:0]  r_want;

    // page walk
    logic [PGC_W-1:0]  r_pg;
    logic [PGC_W-1:0]  r_open;
    logic [BASE_W-1:0] r_base;
    logic              r_fresh;
    logic [SHC_W-1:0]  r_cnt  [MAX_PAGES];
    logic [DIM_W-1:0]  r_fill [MAX_PAGES];
    logic [SHC_W-1:0]  r_n;
    logic [DIM_W-1:0]  r_left;
    logic [DIM_W-1:0]  r_fill_cur;

    // shelf scan
    logic [SHC_W-1:0]  r_issue;
    logic              r_chk_valid;
    logic [SHC_W-1:0]  r_chk_idx;

    // shelf memory
    t_shelf            r_mem [DEPTH];
    t_shelf            r_rd_data;

    // result and output register
    t_status              r_res_status;
    logic [PAGE_OUT_W-1:0] r_res_page;
    logic [POS_W-1:0]     r_res_x;
    logic [POS_W-1:0]     r_res_y;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    // combinational control
    logic              accept;
    logic              oversize;
    logic              match;
    logic              hit;
    logic              try_fail;
    logic              rd_en;
    logic              mem_we;
    logic              shelf_open;
    logic              page_open;
    logic              out_load;
    logic [AD_W-1:0]   rd_addr;
    logic [AD_W-1:0]   mem_waddr;
    t_shelf            mem_wdata;
    logic [DIM_W-1:0]  want_clip;
    logic [PROD_W-1:0] h7;
    logic [DIM_W-1:0]  pw_eff;
    logic [DIM_W-1:0]  ph_eff;
    logic [RECIP_W-1:0] want_prod;
    logic [DIM_W-1:0]  in_w;
    logic [DIM_W-1:0]  in_h;
    logic [PGI_W-1:0]  pg_idx;

    assign in_w   = s_axis_tdata[DIM_W-1:0];
    assign in_h   = s_axis_tdata[2*DIM_W-1:DIM_W];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pg_idx = r_pg[PGI_W-1:0];

    // page sizes above 4096 act as 4096
    assign pw_eff = (r_cfg_pw > DIM_LIMIT) ? DIM_LIMIT : r_cfg_pw;
    assign ph_eff = (r_cfg_ph > DIM_LIMIT) ? DIM_LIMIT : r_cfg_ph;

    // new shelf height h*11/10 by reciprocal multiply
    assign want_prod = RECIP_W'(r_h11) * RECIP_10;

    assign oversize = (r_w > r_pw) || (r_h > r_ph);

    // shelf fit: height >= h, floor(height*7/10) <= h, room left on the row
    assign h7    = PROD_W'(r_rd_data.height) * FIT_NUM;
    assign match = (r_rd_data.height >= r_h) && (h7 <= r_h10p9) &&
                   (r_rd_data.cursor <= r_pw) && ((r_pw - r_rd_data.cursor) >= r_w);
    assign hit   = (r_state == ST_SCAN) && r_chk_valid && match;

    // new shelf on the current page
    assign try_fail  = (r_left < r_h) || (r_n >= SHELVES_MAX);
    assign want_clip = (r_want > r_left) ? r_left : r_want;

    assign rd_addr = AD_W'(r_base) + AD_W'(r_issue);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = oversize ? ST_DONE : ST_NEXT;
            end
            ST_NEXT: begin
                if (r_pg < r_open) n_state = ST_PAGE;
                else if (r_open == PAGES_MAX) n_state = ST_DONE;
                else n_state = ST_PAGE;
            end
            ST_PAGE: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) n_state = ST_DONE;
                else if (!r_chk_valid && (r_issue == r_n)) n_state = ST_TRYNEW;
            end
            ST_TRYNEW: begin
                if (!try_fail || r_fresh) n_state = ST_DONE;
                else n_state = ST_NEXT;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        shelf_open    = 1'b0;
        page_open     = 1'b0;
        out_load      = 1'b0;
        mem_waddr     = AD_W'(r_base) + AD_W'(r_chk_idx);
        mem_wdata     = r_rd_data;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_NEXT: begin
                page_open = (r_pg >= r_open) && (r_open != PAGES_MAX);
            end
            ST_SCAN: begin
                rd_en = !hit && (r_issue < r_n);
                if (hit) begin
                    mem_we           = 1'b1;
                    mem_wdata.cursor = r_rd_data.cursor + r_w;
                end
            end
            ST_TRYNEW: begin
                if (!try_fail) begin
                    shelf_open        = 1'b1;
                    mem_we            = 1'b1;
                    mem_waddr         = AD_W'(r_base) + AD_W'(r_n);
                    mem_wdata.height  = want_clip;
                    mem_wdata.cursor  = r_w;
                    mem_wdata.start_y = r_fill_cur;
                end
            end
            ST_DONE: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pw <= PW_RESET;
            r_cfg_ph <= PH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PAGE_WIDTH:  r_cfg_pw <= i_cfg_wdata;
                CFG_PAGE_HEIGHT: r_cfg_ph <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // page count, per-page shelf counts and fill lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            for (int p = 0; p < MAX_PAGES; p++) begin
                r_cnt[p]  <= '0;
                r_fill[p] <= '0;
            end
        end else if (page_open) begin
            r_open         <= r_open + 1'b1;
            r_cnt[pg_idx]  <= '0;
            r_fill[pg_idx] <= '0;
        end else if (shelf_open) begin
            r_cnt[pg_idx]  <= r_n + 1'b1;
            r_fill[pg_idx] <= r_fill_cur + want_clip;
        end
    end

    // request capture and search datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w     <= in_w;
            r_h     <= in_h;
            r_pw    <= pw_eff;
            r_ph    <= ph_eff;
            r_h10p9 <= PROD_W'(in_h) * FIT_DEN + PROD_W'(FIT_DEN - 1'b1);
            r_h11   <= PROD_W'(in_h) * GROW_NUM;
        end
        case (r_state)
            ST_PREP: begin
                r_want  <= want_prod[RECIP_SHIFT +: DIM_W];
                r_pg    <= '0;
                r_base  <= '0;
                r_fresh <= 1'b0;
            end
            ST_NEXT: begin
                if (page_open) r_fresh <= 1'b1;
            end
            ST_PAGE: begin
                r_n         <= r_cnt[pg_idx];
                r_fill_cur  <= r_fill[pg_idx];
                r_left      <= (r_fill[pg_idx] >= r_ph) ? '0 : r_ph - r_fill[pg_idx];
                r_issue     <= '0;
                r_chk_valid <= 1'b0;
            end
            ST_SCAN: begin
                r_chk_valid <= rd_en;
                if (rd_en) begin
                    r_issue   <= r_issue + 1'b1;
                    r_chk_idx <= r_issue;
                end
            end
            ST_TRYNEW: begin
                if (try_fail && !r_fresh) begin
                    r_pg   <= r_pg + 1'b1;
                    r_base <= r_base + BASE_STEP;
                end
            end
            default: begin
            end
        endcase
    end

    // result capture
    always_ff @(posedge i_clk) begin
        r_res_page <= PAGE_OUT_W'(r_pg);
        case (r_state)
            ST_PREP: begin
                r_res_status <= STAT_OVERSIZE;
                r_res_x      <= '0;
                r_res_y      <= '0;
            end
            ST_NEXT: begin
                r_res_status <= STAT_FULL;
                r_res_x      <= '0;
                r_res_y      <= '0;
            end
            ST_SCAN: begin
                r_res_status <= STAT_PLACED;
                r_res_x      <= clip_pos(r_rd_data.cursor);
                r_res_y      <= clip_pos(r_rd_data.start_y);
            end
            ST_TRYNEW: begin
                r_res_status <= try_fail ? STAT_FULL : STAT_PLACED;
                r_res_x      <= '0;
                r_res_y      <= try_fail ? '0 : clip_pos(r_fill_cur);
            end
            default: begin
            end
        endcase
    end

    // shelf memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= {3'b000, r_res_y, r_res_x,
                           (r_res_status == STAT_PLACED) ? r_res_page : '0,
                           r_res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `SAA_ASSERT_IMP(a_open_bound, 1'b1, r_open <= PAGES_MAX, "page count beyond limit")
    `SAA_ASSERT_IMP(a_no_rw_clash, mem_we, !rd_en, "shelf read and write in one cycle")
    `SAA_ASSERT_IMP(a_scan_bound, r_state == ST_SCAN, r_issue <= r_n, "scan past shelf count")
    `SAA_ASSERT_IMP(a_shelf_slot, shelf_open, r_n < SHELVES_MAX, "shelf opened with no slot")
    `SAA_ASSERT_NXT(a_accept_prep, accept, r_state == ST_PREP, "accepted request not started")

endmodule
